### sv/positional_ordered_list_assert.svh
// assertion macros for the positional ordered list
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

// same-cycle implication
`define POL_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional_ordered_list check failed");

// next-cycle implication
`define POL_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional_ordered_list check failed");

`endif

### sv/pol_pkg.sv
// package with widths, command and status codes for the positional ordered list
package pol_pkg;

	localparam int POL_CAPACITY = 16;

	localparam int CMD_W = 3;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int ST_W  = 3;
	localparam int IDX_W = 4;
	localparam int LEN_W = 5;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT_AFTER = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP_END      = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DELETE_AT    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_DUMP         = 3'd6;

	localparam logic [ST_W-1:0] ST_OK     = 3'd0;
	localparam logic [ST_W-1:0] ST_OVER   = 3'd1;
	localparam logic [ST_W-1:0] ST_UNDER  = 3'd2;
	localparam logic [ST_W-1:0] ST_BADPOS = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY  = 3'd4;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [VAL_W-1:0] read_value;
		logic [IDX_W-1:0] read_index;
		logic [LEN_W-1:0] length;
		logic             last;
	} result_t;

endpackage

### sv/positional_ordered_list.sv
// positional ordered list: bounded list of signed values kept in one synchronous memory
//
// A command transfers at a rising edge with start high and busy low: cmd, position
// and value. Every command ends with one result on the result ports, shown for exactly
// one cycle with result_valid high; a dump of a non-empty list gives one result per
// entry, front to end, on consecutive cycles, and last marks the final one.
// The entries sit in a memory with one read and one write per cycle and a registered
// read. Inserts and deletes move the entries behind the touched slot one at a time,
// one read and one trailing write per cycle.
// From the transfer to the (first) result: a command that needs no move, or a refused
// command, emits its result from the idle state; an insert reads the last entry, moves
// the entries in S_INS, then writes the new value and emits in S_PUT; a delete moves the
// entries in S_DEL and emits with the last move; a dump reads the front entry, then emits
// one result per entry in S_DUMP. Each result is emitted into a register before it shows.
// busy is high while moves or a dump are running, and no new command is taken then;
// the single memory port pair makes the moves run one entry at a time.
// The receiver cannot stall: each result is there for its one cycle only.
// Reset empties the list; memory contents are not cleared and are never read
// before being written.
module positional_ordered_list #(
	parameter int CAPACITY = pol_pkg::POL_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [pol_pkg::CMD_W-1:0]         cmd,
	input  logic [pol_pkg::POS_W-1:0]         position,
	input  logic signed [pol_pkg::VAL_W-1:0]  value,
	output logic                              result_valid,
	output logic [pol_pkg::ST_W-1:0]          status,
	output logic signed [pol_pkg::VAL_W-1:0]  read_value,
	output logic [pol_pkg::IDX_W-1:0]         read_index,
	output logic [pol_pkg::LEN_W-1:0]         length,
	output logic                              last
);

	`include "positional_ordered_list_assert.svh"

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > pol_pkg::POS_W) ? LW : pol_pkg::POS_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_PUT  = 3'd2;
	localparam logic [2:0] S_DEL  = 3'd3;
	localparam logic [2:0] S_DUMP = 3'd4;

	logic [pol_pkg::VAL_W-1:0] mem_q [CAPACITY];
	logic [pol_pkg::VAL_W-1:0] rd_data_q;

	logic [2:0]                state_q, state_d;
	logic [AW-1:0]             ptr_q, ptr_d;
	logic [AW-1:0]             at_q, at_d;
	logic [pol_pkg::VAL_W-1:0] val_q, val_d;
	logic [LW-1:0]             len_q, len_d;
	logic                      res_valid_q;
	pol_pkg::result_t          res_q;

	logic                      mem_we, mem_re;
	logic [AW-1:0]             mem_waddr, mem_raddr;
	logic [pol_pkg::VAL_W-1:0] mem_wdata;

	logic                      emit;
	pol_pkg::result_t          emit_res;

	logic                      full, empty, pos_bad;
	logic [CW-1:0]             pos_c, len_c;
	logic [AW-1:0]             len_a, len_m1_a, ins_at, del_at;

	assign full     = (len_q == LW'(CAPACITY));
	assign empty    = (len_q == '0);
	assign pos_c    = CW'(position);
	assign len_c    = CW'(len_q);
	assign pos_bad  = (pos_c == '0) || (pos_c > len_c);
	assign len_a    = AW'(len_q);
	assign len_m1_a = AW'(len_q - LW'(1));

	assign ins_at = (cmd == pol_pkg::CMD_PUSH_FRONT) ? '0 :
	                (cmd == pol_pkg::CMD_APPEND)     ? len_a :
	                empty                            ? '0 : AW'(position);
	assign del_at = (cmd == pol_pkg::CMD_POP_FRONT) ? '0 :
	                (cmd == pol_pkg::CMD_POP_END)   ? len_m1_a :
	                AW'(position - pol_pkg::POS_W'(1));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = rd_data_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		state_d   = state_q;
		ptr_d     = ptr_q;
		at_d      = at_q;
		val_d     = val_q;
		len_d     = len_q;
		emit      = 1'b0;
		emit_res.status     = pol_pkg::ST_OK;
		emit_res.read_value = '0;
		emit_res.read_index = '0;
		emit_res.last       = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd)
						pol_pkg::CMD_PUSH_FRONT, pol_pkg::CMD_APPEND,
						pol_pkg::CMD_INSERT_AFTER: begin
							if (full) begin
								emit            = 1'b1;
								emit_res.status = pol_pkg::ST_OVER;
							end else if (cmd == pol_pkg::CMD_INSERT_AFTER && !empty && pos_bad) begin
								emit            = 1'b1;
								emit_res.status = pol_pkg::ST_BADPOS;
							end else if (ins_at == len_a) begin
								mem_we    = 1'b1;
								mem_waddr = ins_at;
								mem_wdata = value;
								len_d     = LW'(len_q + LW'(1));
								emit      = 1'b1;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = len_m1_a;
								ptr_d     = len_m1_a;
								at_d      = ins_at;
								val_d     = value;
								state_d   = S_INS;
							end
						end
						pol_pkg::CMD_POP_FRONT, pol_pkg::CMD_POP_END,
						pol_pkg::CMD_DELETE_AT: begin
							if (empty) begin
								emit            = 1'b1;
								emit_res.status = pol_pkg::ST_UNDER;
							end else if (cmd == pol_pkg::CMD_DELETE_AT && pos_bad) begin
								emit            = 1'b1;
								emit_res.status = pol_pkg::ST_BADPOS;
							end else if (del_at == len_m1_a) begin
								len_d = LW'(len_q - LW'(1));
								emit  = 1'b1;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(del_at + AW'(1));
								ptr_d     = AW'(del_at + AW'(1));
								state_d   = S_DEL;
							end
						end
						pol_pkg::CMD_DUMP: begin
							if (empty) begin
								emit            = 1'b1;
								emit_res.status = pol_pkg::ST_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								ptr_d     = '0;
								state_d   = S_DUMP;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_INS: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(ptr_q + AW'(1));
				if (ptr_q == at_q) begin
					state_d = S_PUT;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = AW'(ptr_q - AW'(1));
					ptr_d     = AW'(ptr_q - AW'(1));
				end
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = at_q;
				mem_wdata = val_q;
				len_d     = LW'(len_q + LW'(1));
				emit      = 1'b1;
				state_d   = S_IDLE;
			end
			S_DEL: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(ptr_q - AW'(1));
				if (ptr_q == len_m1_a) begin
					len_d   = LW'(len_q - LW'(1));
					emit    = 1'b1;
					state_d = S_IDLE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = AW'(ptr_q + AW'(1));
					ptr_d     = AW'(ptr_q + AW'(1));
				end
			end
			S_DUMP: begin
				emit                = 1'b1;
				emit_res.read_value = rd_data_q;
				emit_res.read_index = pol_pkg::IDX_W'(ptr_q);
				emit_res.last       = (ptr_q == len_m1_a);
				if (ptr_q == len_m1_a) begin
					state_d = S_IDLE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = AW'(ptr_q + AW'(1));
					ptr_d     = AW'(ptr_q + AW'(1));
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		emit_res.length = pol_pkg::LEN_W'(len_d);
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			len_q       <= len_d;
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		at_q  <= at_d;
		val_q <= val_d;
		if (emit) begin
			res_q <= emit_res;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign status       = res_q.status;
	assign read_value   = $signed(res_q.read_value);
	assign read_index   = res_q.read_index;
	assign length       = res_q.length;
	assign last         = res_q.last;

	`POL_ASSERT_IMP(a_len_bound, 1'b1, len_q <= LW'(CAPACITY))
	`POL_ASSERT_NEXT(a_cmd_answered, start && !busy, res_valid_q || busy)
	`POL_ASSERT_NEXT(a_dump_stream, res_valid_q && !res_q.last, res_valid_q)
	`POL_ASSERT_NEXT(a_dump_index, res_valid_q && !res_q.last,
		res_q.read_index == pol_pkg::IDX_W'($past(res_q.read_index) + pol_pkg::IDX_W'(1)))
	`POL_ASSERT_NEXT(a_len_step, 1'b1,
		len_q == $past(len_q) || len_q == LW'($past(len_q) + LW'(1)) ||
		LW'(len_q + LW'(1)) == $past(len_q))

endmodule
